// File: sv/shape_outline_tessellator_assert.svh
// ----------------------------------------------------------------------------
// Shape outline tessellator assertion macros
// Shared concurrent assertion forms, clocked on clk, quiet while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SHAPE_OUTLINE_TESSELLATOR_ASSERT_SVH
`define SHAPE_OUTLINE_TESSELLATOR_ASSERT_SVH

// Same-cycle implication.
`define SOT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SOT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/sot_pkg.sv
// ----------------------------------------------------------------------------
// Shape outline tessellator package
// Shape kinds, queue entry type, outline tables and saturation helpers.
// ----------------------------------------------------------------------------
package sot_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int QDEPTH_DEF    = 2;
	localparam int PT_COUNT      = 26;
	localparam int HALF_COUNT    = 13;
	localparam int ACCW          = 68;
	localparam int MW            = 33;

	localparam logic [1:0] OP_CIRCLE  = 2'd0;
	localparam logic [1:0] OP_SEGMENT = 2'd1;
	localparam logic [1:0] OP_POLYGON = 2'd2;
	localparam logic [1:0] OP_NONE    = 2'd3;

	localparam logic [1:0] KIND_CIRC = 2'd0;
	localparam logic [1:0] KIND_CAPS = 2'd1;
	localparam logic [1:0] KIND_LINE = 2'd2;
	localparam logic [1:0] KIND_POLY = 2'd3;

	// Unit-circle outlines in units of 1/10000, x then y per point.
	localparam int CIRC_TBL [2*PT_COUNT] = '{
		0, 10000, 2588, 9659, 5000, 8660, 7071, 7071,
		8660, 5000, 9659, 2588, 10000, 0, 9659, -2588,
		8660, -5000, 7071, -7071, 5000, -8660, 2588, -9659,
		0, -10000, -2588, -9659, -5000, -8660, -7071, -7071,
		-8660, -5000, -9659, -2588, -10000, 0, -9659, 2588,
		-8660, 5000, -7071, 7071, -5000, 8660, -2588, 9659,
		0, 10000, 0, 4500
	};

	localparam int CAPS_TBL [2*PT_COUNT] = '{
		0, 10000, 2588, 9659, 5000, 8660, 7071, 7071,
		8660, 5000, 9659, 2588, 10000, 0, 9659, -2588,
		8660, -5000, 7071, -7071, 5000, -8660, 2588, -9659,
		0, -10000,
		0, -10000, -2588, -9659, -5000, -8660, -7071, -7071,
		-8660, -5000, -9659, -2588, -10000, 0, -9659, 2588,
		-8660, 5000, -7071, 7071, -5000, 8660, -2588, 9659,
		0, 10000
	};

	typedef struct packed {
		logic [1:0]         kind;
		logic               rot;
		logic               plast;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] rx;
		logic signed [31:0] ry;
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] bx;
		logic signed [31:0] by;
		logic [30:0]        rad;
		logic signed [31:0] mx;
		logic signed [31:0] my;
		logic [31:0]        half;
		logic signed [31:0] nx;
		logic signed [31:0] ny;
	} sot_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} sot_qstat_t;

	// Table entry to fixed point, round half away from zero (elaboration only).
	function automatic longint unit_of(input int c, input int frac);
		longint one;
		one = longint'(1) << frac;
		if (c >= 0)
			return (longint'(c) * one + 5000) / 10000;
		return -((longint'(-c) * one + 5000) / 10000);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [ACCW-1:0] v);
		if (v > ACCW'(64'sd2147483647))
			return 32'sh7FFF_FFFF;
		if (v < -ACCW'(64'sd2147483648))
			return 32'sh8000_0000;
		return v[31:0];
	endfunction

endpackage

// File: sv/shape_outline_tessellator.sv
// ----------------------------------------------------------------------------
// Shape outline tessellator
// Turns circles, capsules, segments and polygon vertices into outline vertices.
// ----------------------------------------------------------------------------
//  channel | ports                                   | dir | transaction
//  --------+-----------------------------------------+-----+------------------
//  in      | in_valid/in_stall, opcode .. poly_last  | in  | one shape item
//  vert    | vert_valid/vert_stall, vert_x/y, last   | out | one outline vertex
//
//  A circle gives 26 vertices and a capsule 26, each paced by the shared
//  33x33 multiplier (two scale products, four per rotation; a capsule also
//  turns by its direction). A plain segment gives 2 vertices and a polygon
//  vertex one; the back end pops the queue once per shape. A capsule's square
//  root and FRAC_BITS + 2 bit direction divide in the front end are overlapped
//  with the previous shape's vertices through the two-entry queue.
//  arst_n clears control state; the block is ready the cycle after release.
//  in_stall rises while the front end works on a capsule or the queue is full;
//  vert_stall on a waiting vertex holds the back end.
// ----------------------------------------------------------------------------
module shape_outline_tessellator #(
	parameter int FRAC_BITS   = sot_pkg::FRAC_BITS_DEF,
	parameter int QUEUE_DEPTH = sot_pkg::QDEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         opcode,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] rot_x,
	input  logic signed [31:0] rot_y,
	input  logic signed [31:0] point_a_x,
	input  logic signed [31:0] point_a_y,
	input  logic signed [31:0] point_b_x,
	input  logic signed [31:0] point_b_y,
	input  logic [30:0]        radius,
	input  logic               poly_last,
	output logic               vert_valid,
	input  logic               vert_stall,
	output logic signed [31:0] vert_x,
	output logic signed [31:0] vert_y,
	output logic               last_vertex
);

	// Classified shapes travel from front to back through the queue.
	sot_pkg::sot_entry_t push_data, rd_data;
	sot_pkg::sot_qstat_t q_stat;
	logic push, pop;

	// Front: accept, classify, capsule root and direction divide.
	sot_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.rot_x     (rot_x),
		.rot_y     (rot_y),
		.point_a_x (point_a_x),
		.point_a_y (point_a_y),
		.point_b_x (point_b_x),
		.point_b_y (point_b_y),
		.radius    (radius),
		.poly_last (poly_last),
		.push      (push),
		.push_data (push_data),
		.q_stat    (q_stat)
	);

	// Queue: decouple the two halves so each can stall on its own.
	sot_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (push_data),
		.pop     (pop),
		.rd_data (rd_data),
		.stat    (q_stat)
	);

	// Back: advance vertex by vertex, hold the result while stalled.
	sot_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.rd_data     (rd_data),
		.q_stat      (q_stat),
		.pop         (pop),
		.vert_valid  (vert_valid),
		.vert_stall  (vert_stall),
		.vert_x      (vert_x),
		.vert_y      (vert_y),
		.last_vertex (last_vertex)
	);

endmodule

// File: sv/sot_queue.sv
// ----------------------------------------------------------------------------
// Shape outline tessellator command queue
// Short register FIFO of classified shapes between front and back.
// ----------------------------------------------------------------------------
module sot_queue #(
	parameter int DEPTH = sot_pkg::QDEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  sot_pkg::sot_entry_t wr_data,
	input  logic                pop,
	output sot_pkg::sot_entry_t rd_data,
	output sot_pkg::sot_qstat_t stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	sot_pkg::sot_entry_t mem_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;

	assign stat.full  = (cnt_q == CW'(DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign rd_data    = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (pop)
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// File: sv/sot_front.sv
// ----------------------------------------------------------------------------
// Shape outline tessellator front end
// Accepts shapes, classifies them and works out capsule length and direction.
// ----------------------------------------------------------------------------
module sot_front #(
	parameter int FRAC_BITS = sot_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          opcode,
	input  logic signed [31:0]  pos_x,
	input  logic signed [31:0]  pos_y,
	input  logic signed [31:0]  rot_x,
	input  logic signed [31:0]  rot_y,
	input  logic signed [31:0]  point_a_x,
	input  logic signed [31:0]  point_a_y,
	input  logic signed [31:0]  point_b_x,
	input  logic signed [31:0]  point_b_y,
	input  logic [30:0]         radius,
	input  logic                poly_last,
	output logic                push,
	output sot_pkg::sot_entry_t push_data,
	input  sot_pkg::sot_qstat_t q_stat
);

	localparam int QW = FRAC_BITS + 2;
	localparam int CW = $clog2(QW + 1);
	localparam logic signed [31:0] TENTH = 32'(((1 << FRAC_BITS) + 5) / 10);
	localparam logic signed [31:0] ONE   = 32'(1 << FRAC_BITS);

	localparam logic [2:0] F_IDLE = 3'd0;
	localparam logic [2:0] F_SQX  = 3'd1;
	localparam logic [2:0] F_SQY  = 3'd2;
	localparam logic [2:0] F_ROOT = 3'd3;
	localparam logic [2:0] F_LEN  = 3'd4;
	localparam logic [2:0] F_DIV  = 3'd5;
	localparam logic [2:0] F_FIN  = 3'd6;
	localparam logic [2:0] F_PUSH = 3'd7;

	logic [2:0] fst_q;
	sot_pkg::sot_entry_t ent_q, ent_in;
	logic accept, in_rot, is_caps;
	logic signed [32:0] dx_w, dy_w, sumx_w, sumy_w;
	logic [32:0] adx_w, ady_w, adx_q, ady_q;
	logic halve_w, halved_q, sx_q, sy_q;
	logic [31:0] ux_q, uy_q, mop_w;
	logic [63:0] sq_w, v_q, res_q, bit_q, trial_w;
	logic [32:0] len_w, len_q, remx_q, remy_q;
	logic [33:0] r2x_w, r2y_w;
	logic gex_w, gey_w;
	logic [QW-1:0] nlox_q, nloy_q, qx_q, qy_q;
	logic [CW-1:0] dcnt_q;
	logic [31:0] qxm_w, qym_w;

	assign in_stall = (fst_q != F_IDLE) || q_stat.full;
	assign accept   = in_valid && !in_stall;

	assign in_rot = !(rot_x >= -TENTH && rot_x <= TENTH && rot_y >= -TENTH && rot_y <= TENTH);
	assign is_caps = (opcode == sot_pkg::OP_SEGMENT) && (radius != '0);

	assign dx_w   = 33'(point_b_x) - 33'(point_a_x);
	assign dy_w   = 33'(point_b_y) - 33'(point_a_y);
	assign sumx_w = 33'(point_a_x) + 33'(point_b_x);
	assign sumy_w = 33'(point_a_y) + 33'(point_b_y);
	assign adx_w  = dx_w[32] ? 33'(-dx_w) : dx_w;
	assign ady_w  = dy_w[32] ? 33'(-dy_w) : dy_w;
	assign halve_w = (adx_w[32:31] != 2'b00) || (ady_w[32:31] != 2'b00);

	always_comb begin
		ent_in       = '0;
		ent_in.rot   = in_rot;
		ent_in.plast = poly_last;
		ent_in.px    = pos_x;
		ent_in.py    = pos_y;
		ent_in.rx    = rot_x;
		ent_in.ry    = rot_y;
		ent_in.ax    = point_a_x;
		ent_in.ay    = point_a_y;
		ent_in.bx    = point_b_x;
		ent_in.by    = point_b_y;
		ent_in.rad   = radius;
		ent_in.mx    = 32'(sumx_w >>> 1);
		ent_in.my    = 32'(sumy_w >>> 1);
		unique case (opcode)
			sot_pkg::OP_CIRCLE:  ent_in.kind = sot_pkg::KIND_CIRC;
			sot_pkg::OP_SEGMENT: ent_in.kind = is_caps ? sot_pkg::KIND_CAPS : sot_pkg::KIND_LINE;
			default:             ent_in.kind = sot_pkg::KIND_POLY;
		endcase
	end

	assign push = (accept && (opcode != sot_pkg::OP_NONE) && !is_caps) ||
	              ((fst_q == F_PUSH) && !q_stat.full);
	assign push_data = (fst_q == F_PUSH) ? ent_q : ent_in;

	// Squares of the difference (halved if too long), one per cycle through one multiplier.
	assign mop_w   = (fst_q == F_SQX) ? ux_q : uy_q;
	assign sq_w    = mop_w * mop_w;
	assign trial_w = res_q + bit_q;
	assign len_w   = halved_q ? {res_q[31:0], 1'b0} : {1'b0, res_q[31:0]};

	assign r2x_w = {remx_q, nlox_q[QW-1]};
	assign r2y_w = {remy_q, nloy_q[QW-1]};
	assign gex_w = (r2x_w >= {1'b0, len_q});
	assign gey_w = (r2y_w >= {1'b0, len_q});
	assign qxm_w = 32'(qx_q);
	assign qym_w = 32'(qy_q);

	always_ff @(posedge clk) begin
		if (accept && is_caps) begin
			ent_q    <= ent_in;
			adx_q    <= adx_w;
			ady_q    <= ady_w;
			sx_q     <= dx_w[32];
			sy_q     <= dy_w[32];
			halved_q <= halve_w;
			ux_q     <= halve_w ? adx_w[32:1] : adx_w[31:0];
			uy_q     <= halve_w ? ady_w[32:1] : ady_w[31:0];
		end
		unique case (fst_q)
			F_SQX: v_q <= sq_w;
			F_SQY: begin
				v_q   <= v_q + sq_w;
				res_q <= '0;
				bit_q <= 64'h4000_0000_0000_0000;
			end
			F_ROOT: begin
				if (v_q >= trial_w) begin
					v_q   <= v_q - trial_w;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			F_LEN: begin
				len_q       <= len_w;
				ent_q.half  <= len_w[32:1];
				ent_q.nx    <= ONE;
				ent_q.ny    <= '0;
				remx_q      <= {2'b00, adx_q[32:2]};
				remy_q      <= {2'b00, ady_q[32:2]};
				nlox_q      <= {adx_q[1:0], {FRAC_BITS{1'b0}}};
				nloy_q      <= {ady_q[1:0], {FRAC_BITS{1'b0}}};
				qx_q        <= '0;
				qy_q        <= '0;
				dcnt_q      <= CW'(QW);
			end
			F_DIV: begin
				remx_q <= gex_w ? 33'(r2x_w - {1'b0, len_q}) : r2x_w[32:0];
				remy_q <= gey_w ? 33'(r2y_w - {1'b0, len_q}) : r2y_w[32:0];
				nlox_q <= nlox_q << 1;
				nloy_q <= nloy_q << 1;
				qx_q   <= {qx_q[QW-2:0], gex_w};
				qy_q   <= {qy_q[QW-2:0], gey_w};
				dcnt_q <= dcnt_q - 1'b1;
			end
			F_FIN: begin
				ent_q.nx <= sx_q ? -qxm_w : qxm_w;
				ent_q.ny <= sy_q ? -qym_w : qym_w;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fst_q <= F_IDLE;
		end else begin
			unique case (fst_q)
				F_IDLE: if (accept && is_caps) fst_q <= F_SQX;
				F_SQX:  fst_q <= F_SQY;
				F_SQY:  fst_q <= F_ROOT;
				F_ROOT: if (bit_q[0]) fst_q <= F_LEN;
				F_LEN:  fst_q <= (len_w == '0) ? F_PUSH : F_DIV;
				F_DIV:  if (dcnt_q == CW'(1)) fst_q <= F_FIN;
				F_FIN:  fst_q <= F_PUSH;
				F_PUSH: if (!q_stat.full) fst_q <= F_IDLE;
				default: fst_q <= F_IDLE;
			endcase
		end
	end

endmodule

// File: sv/sot_back.sv
// ----------------------------------------------------------------------------
// Shape outline tessellator back end
// Walks each queued shape, one vertex at a time, through a shared multiplier.
// ----------------------------------------------------------------------------
`include "shape_outline_tessellator_assert.svh"

module sot_back #(
	parameter int FRAC_BITS = sot_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sot_pkg::sot_entry_t rd_data,
	input  sot_pkg::sot_qstat_t q_stat,
	output logic                pop,
	output logic                vert_valid,
	input  logic                vert_stall,
	output logic signed [31:0]  vert_x,
	output logic signed [31:0]  vert_y,
	output logic                last_vertex
);

	localparam int UW   = FRAC_BITS + 2;
	localparam int MW   = sot_pkg::MW;
	localparam int ACCW = sot_pkg::ACCW;

	localparam logic [3:0] B_IDLE  = 4'd0;
	localparam logic [3:0] B_START = 4'd1;
	localparam logic [3:0] B_SX    = 4'd2;
	localparam logic [3:0] B_SY    = 4'd3;
	localparam logic [3:0] B_SYW   = 4'd4;
	localparam logic [3:0] B_R0    = 4'd5;
	localparam logic [3:0] B_R1    = 4'd6;
	localparam logic [3:0] B_R2    = 4'd7;
	localparam logic [3:0] B_R3    = 4'd8;
	localparam logic [3:0] B_R4    = 4'd9;
	localparam logic [3:0] B_EMIT  = 4'd10;

	logic signed [UW-1:0] circ_u [2*sot_pkg::PT_COUNT];
	logic signed [UW-1:0] caps_u [2*sot_pkg::PT_COUNT];

	for (genvar g = 0; g < 2*sot_pkg::PT_COUNT; g++) begin : g_tab
		assign circ_u[g] = UW'(sot_pkg::unit_of(sot_pkg::CIRC_TBL[g], FRAC_BITS));
		assign caps_u[g] = UW'(sot_pkg::unit_of(sot_pkg::CAPS_TBL[g], FRAC_BITS));
	end

	logic [3:0] st_q;
	sot_pkg::sot_entry_t ent_q;
	logic [4:0] idx_q, cnt_w;
	logic phase_q, last_w, out_free, is_caps;
	logic [5:0] tidx_w;
	logic signed [UW-1:0] u_w;
	logic signed [MW-1:0] ma_w, mb_w, c_w, s_w;
	logic signed [2*MW-1:0] prod_q, fl_w;
	logic signed [ACCW-1:0] fle_w, accx_q, accy_q, half_e;
	logic signed [31:0] x_q, y_q, rxv_w, ryv_w;
	logic signed [31:0] vx_q, vy_q;
	logic vv_q, vl_q;

	assign is_caps = (ent_q.kind == sot_pkg::KIND_CAPS);
	assign pop     = (st_q == B_IDLE) && !q_stat.empty;

	always_comb begin
		unique case (ent_q.kind)
			sot_pkg::KIND_LINE: cnt_w = 5'd2;
			sot_pkg::KIND_POLY: cnt_w = 5'd1;
			default:            cnt_w = 5'(sot_pkg::PT_COUNT);
		endcase
	end
	assign last_w = (ent_q.kind == sot_pkg::KIND_POLY) ? ent_q.plast : (idx_q == cnt_w - 5'd1);

	// x component in the SX step, y component otherwise.
	assign tidx_w = {idx_q, (st_q != B_SX)};
	assign u_w    = is_caps ? caps_u[tidx_w] : circ_u[tidx_w];

	assign c_w = phase_q ? MW'(ent_q.rx) : MW'(ent_q.nx);
	assign s_w = phase_q ? MW'(ent_q.ry) : MW'(ent_q.ny);

	always_comb begin
		ma_w = '0;
		mb_w = '0;
		unique case (st_q) inside
			B_SX, B_SY: begin
				ma_w = MW'(u_w);
				mb_w = $signed({2'b00, ent_q.rad});
			end
			B_R0: begin ma_w = MW'(x_q); mb_w = c_w; end
			B_R1: begin ma_w = MW'(y_q); mb_w = s_w; end
			B_R2: begin ma_w = MW'(x_q); mb_w = s_w; end
			B_R3: begin ma_w = MW'(y_q); mb_w = c_w; end
			default: ;
		endcase
	end

	assign fl_w   = prod_q >>> FRAC_BITS;
	assign fle_w  = ACCW'(fl_w);
	assign half_e = ACCW'($signed({1'b0, ent_q.half}));
	assign rxv_w  = sot_pkg::sat32(accx_q);
	assign ryv_w  = sot_pkg::sat32(accy_q + fle_w);
	assign out_free = !vv_q || !vert_stall;

	always_ff @(posedge clk) begin
		prod_q <= ma_w * mb_w;
		if (pop)
			ent_q <= rd_data;
		unique case (st_q)
			B_START: begin
				if (ent_q.kind == sot_pkg::KIND_LINE && idx_q != '0) begin
					x_q <= ent_q.bx;
					y_q <= ent_q.by;
				end else begin
					x_q <= ent_q.ax;
					y_q <= ent_q.ay;
				end
			end
			// Each scaled product is used from prod_q in the step after it was issued.
			B_SY: begin
				if (is_caps)
					x_q <= sot_pkg::sat32(fle_w +
					       ((idx_q < 5'(sot_pkg::HALF_COUNT)) ? half_e : -half_e));
				else
					x_q <= sot_pkg::sat32(fle_w + ACCW'(ent_q.ax));
			end
			B_SYW: begin
				if (is_caps)
					y_q <= sot_pkg::sat32(fle_w);
				else
					y_q <= sot_pkg::sat32(fle_w + ACCW'(ent_q.ay));
			end
			B_R1: accx_q <= fle_w;
			B_R2: accx_q <= accx_q - fle_w;
			B_R3: accy_q <= fle_w;
			B_R4: begin
				if (phase_q) begin
					x_q <= rxv_w;
					y_q <= ryv_w;
				end else begin
					x_q <= sot_pkg::sat32(ACCW'(rxv_w) + ACCW'(ent_q.mx));
					y_q <= sot_pkg::sat32(ACCW'(ryv_w) + ACCW'(ent_q.my));
				end
			end
			default: ;
		endcase
		if (st_q == B_EMIT && out_free) begin
			vx_q <= sot_pkg::sat32(ACCW'(ent_q.px) + ACCW'(x_q));
			vy_q <= sot_pkg::sat32(ACCW'(ent_q.py) + ACCW'(y_q));
			vl_q <= last_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= B_IDLE;
			idx_q   <= '0;
			phase_q <= 1'b0;
			vv_q    <= 1'b0;
		end else begin
			if (vv_q && !vert_stall && st_q != B_EMIT)
				vv_q <= 1'b0;
			unique case (st_q)
				B_IDLE: begin
					if (pop) begin
						st_q  <= B_START;
						idx_q <= '0;
					end
				end
				B_START: begin
					phase_q <= 1'b1;
					unique case (ent_q.kind)
						sot_pkg::KIND_LINE: st_q <= B_EMIT;
						sot_pkg::KIND_POLY: st_q <= ent_q.rot ? B_R0 : B_EMIT;
						default:            st_q <= B_SX;
					endcase
				end
				B_SX:  st_q <= B_SY;
				B_SY:  st_q <= B_SYW;
				B_SYW: begin
					phase_q <= !is_caps;
					st_q    <= (is_caps || ent_q.rot) ? B_R0 : B_EMIT;
				end
				B_R0: st_q <= B_R1;
				B_R1: st_q <= B_R2;
				B_R2: st_q <= B_R3;
				B_R3: st_q <= B_R4;
				B_R4: begin
					if (!phase_q && ent_q.rot) begin
						phase_q <= 1'b1;
						st_q    <= B_R0;
					end else begin
						st_q <= B_EMIT;
					end
				end
				B_EMIT: begin
					if (out_free) begin
						vv_q <= 1'b1;
						if (last_w || idx_q == cnt_w - 5'd1) begin
							st_q <= B_IDLE;
						end else begin
							idx_q <= idx_q + 5'd1;
							st_q  <= B_START;
						end
					end
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end

	assign vert_valid  = vv_q;
	assign vert_x      = vx_q;
	assign vert_y      = vy_q;
	assign last_vertex = vl_q;

	`SOT_ASSERT_IMP(a_idx_range, st_q != B_IDLE, idx_q < cnt_w, "vertex index past shape end")
	`SOT_ASSERT_IMP(a_dir_caps, (st_q == B_R0) && !phase_q, is_caps, "direction turn on non-capsule")
	`SOT_ASSERT_IMP(a_rot_set, (st_q == B_R0) && phase_q, ent_q.rot, "rotation without rotate flag")
	`SOT_ASSERT_NXT(a_pop_start, pop, st_q == B_START, "queue pop did not start a shape")

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Shape outline tessellator testbench
// Drives circles, capsules, plain segments and polygon vertices with random
// gaps and vertex-side stalls. Every accepted shape is expanded into the
// expected outline vertices, and each vertex transaction is checked in order.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int  FRAC       = 16;
	localparam longint ONE     = longint'(1) << FRAC;
	localparam longint TENTH   = (ONE + 5) / 10;
	localparam int  IDLE_LIMIT = 5000;
	localparam int  DRAIN_CYC  = 200;

	typedef struct {
		logic [1:0]         op;
		logic signed [31:0] px, py, rx, ry, ax, ay, bx, by;
		logic [30:0]        rad;
		logic               plast;
	} shape_t;

	typedef struct {
		logic signed [31:0] x, y;
		logic               last;
	} vertex_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] opcode = '0;
	logic signed [31:0] pos_x = '0, pos_y = '0, rot_x = '0, rot_y = '0;
	logic signed [31:0] point_a_x = '0, point_a_y = '0, point_b_x = '0, point_b_y = '0;
	logic [30:0] radius = '0;
	logic poly_last = 1'b0;
	logic vert_valid;
	logic vert_stall = 1'b0;
	logic signed [31:0] vert_x, vert_y;
	logic last_vertex;

	shape_t  pending_shapes[$];
	vertex_t expected_verts[$];
	int      mismatches = 0;
	int      idle_cycles = 0;
	int      in_gap = 0;
	int      stall_left = 0;
	bit      burst = 1'b0;

	shape_outline_tessellator DUT (.*);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------- predictor

	function automatic longint sat(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// table entry in 1/10000 units to fixed point, half away from zero
	function automatic longint tbl_fix(input int c);
		if (c >= 0) return (longint'(c) * ONE + 5000) / 10000;
		return -((longint'(-c) * ONE + 5000) / 10000);
	endfunction

	// product shifted back to the fixed-point scale, rounding down
	function automatic longint fmul(input longint a, input longint b);
		return (a * b) >>> FRAC;
	endfunction

	task automatic turn(inout longint x, inout longint y, input longint c, input longint s);
		longint nx, ny;
		nx = fmul(x, c) - fmul(y, s);
		ny = fmul(x, s) + fmul(y, c);
		x = sat(nx);
		y = sat(ny);
	endtask

	function automatic longint unsigned root64(input longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	task automatic push_vert(input longint x, input longint y, input logic last);
		vertex_t v;
		v.x = 32'(sat(x));
		v.y = 32'(sat(y));
		v.last = last;
		expected_verts.push_back(v);
	endtask

	// expand one accepted shape into its outline vertices
	task automatic tessellate(input shape_t s);
		longint px, py, rx, ry, ax, ay, bx, by, rad;
		longint x, y, dx, dy, mx, my, len, half, nx, ny;
		longint unsigned ux, uy;
		bit spin;
		px = s.px; py = s.py; rx = s.rx; ry = s.ry;
		ax = s.ax; ay = s.ay; bx = s.bx; by = s.by;
		rad = longint'({1'b0, s.rad});
		spin = !(rx >= -TENTH && rx <= TENTH && ry >= -TENTH && ry <= TENTH);
		case (s.op)
			sot_pkg::OP_CIRCLE: begin
				for (int i = 0; i < sot_pkg::PT_COUNT; i++) begin
					x = sat(ax + fmul(tbl_fix(sot_pkg::CIRC_TBL[2*i]), rad));
					y = sat(ay + fmul(tbl_fix(sot_pkg::CIRC_TBL[2*i+1]), rad));
					if (spin) turn(x, y, rx, ry);
					push_vert(px + x, py + y, i == sot_pkg::PT_COUNT - 1);
				end
			end
			sot_pkg::OP_SEGMENT: begin
				if (rad == 0) begin
					push_vert(px + ax, py + ay, 1'b0);
					push_vert(px + bx, py + by, 1'b1);
				end else begin
					dx = bx - ax;
					dy = by - ay;
					mx = (ax + bx) >>> 1;
					my = (ay + by) >>> 1;
					ux = dx < 0 ? -dx : dx;
					uy = dy < 0 ? -dy : dy;
					// halve very long differences so the squares fit
					if (ux >= 64'h8000_0000 || uy >= 64'h8000_0000) begin
						ux = ux >> 1;
						uy = uy >> 1;
						len = longint'(root64(ux * ux + uy * uy)) * 2;
					end else begin
						len = longint'(root64(ux * ux + uy * uy));
					end
					half = len >>> 1;
					if (len == 0) begin
						nx = ONE;
						ny = 0;
					end else begin
						nx = (dx * ONE) / len;
						ny = (dy * ONE) / len;
					end
					for (int i = 0; i < sot_pkg::PT_COUNT; i++) begin
						x = fmul(tbl_fix(sot_pkg::CAPS_TBL[2*i]), rad);
						y = sat(fmul(tbl_fix(sot_pkg::CAPS_TBL[2*i+1]), rad));
						x = sat(i < sot_pkg::HALF_COUNT ? x + half : x - half);
						turn(x, y, nx, ny);
						x = sat(x + mx);
						y = sat(y + my);
						if (spin) turn(x, y, rx, ry);
						push_vert(px + x, py + y, i == sot_pkg::PT_COUNT - 1);
					end
				end
			end
			sot_pkg::OP_POLYGON: begin
				x = ax;
				y = ay;
				if (spin) turn(x, y, rx, ry);
				push_vert(px + x, py + y, s.plast);
			end
			default: ;
		endcase
	endtask

	// ---------------------------------------------------------------- stimulus

	function automatic logic [31:0] rnd_val();
		case ($urandom_range(0, 4))
			0: return $urandom();
			1: return 32'($signed($urandom_range(0, 2 << 20)) - (1 << 20));
			2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return 32'($signed($urandom_range(0, 2 << 18)) - (1 << 18));
		endcase
	endfunction

	function automatic shape_t mk(input logic [1:0] op, input logic [31:0] px, py, rx, ry,
			ax, ay, bx, by, input logic [30:0] rad, input logic pl);
		shape_t s;
		s.op = op; s.px = px; s.py = py; s.rx = rx; s.ry = ry;
		s.ax = ax; s.ay = ay; s.bx = bx; s.by = by; s.rad = rad; s.plast = pl;
		return s;
	endfunction

	function automatic shape_t rnd_shape(input logic [1:0] op);
		shape_t s;
		s = mk(op, rnd_val(), rnd_val(), rnd_val(), rnd_val(), rnd_val(), rnd_val(),
			rnd_val(), rnd_val(), '0, 1'b0);
		case ($urandom_range(0, 3))
			0: s.rad = $urandom();
			1: s.rad = 31'h7FFF_FFFF;
			default: s.rad = $urandom_range(0, 1 << 22);
		endcase
		if ($urandom_range(0, 3) == 0) begin
			// rotation near or inside the dead zone
			s.rx = 32'($signed($urandom_range(0, 2 * 6560)) - 6560);
			s.ry = 32'($signed($urandom_range(0, 2 * 6560)) - 6560);
		end
		if (op == sot_pkg::OP_SEGMENT && $urandom_range(0, 3) == 0) s.rad = '0;
		return s;
	endfunction

	initial begin
		int n;
		shape_t s;
		// directed: extremes, each shape kind, dead-zone edges
		pending_shapes.push_back(mk(sot_pkg::OP_CIRCLE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		pending_shapes.push_back(mk(sot_pkg::OP_CIRCLE, 32'h7FFF_FFFF, 32'h8000_0000,
			65536, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 31'h7FFF_FFFF, 0));
		pending_shapes.push_back(mk(sot_pkg::OP_CIRCLE, 100, -100, 6554, -6554,
			5 << 16, 3 << 16, 0, 0, 2 << 16, 0));
		pending_shapes.push_back(mk(sot_pkg::OP_CIRCLE, 0, 0, 6555, 0, 0, 0, 0, 0,
			1 << 16, 0));
		pending_shapes.push_back(mk(sot_pkg::OP_CIRCLE, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF,
			1 << 16, 1 << 16, 0, 0, 10 << 16, 1));
		pending_shapes.push_back(mk(sot_pkg::OP_SEGMENT, 0, 0, 0, 0, 1 << 16, 2 << 16,
			7 << 16, -3 << 16, 0, 0));
		pending_shapes.push_back(mk(sot_pkg::OP_SEGMENT, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			65536, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0));
		// zero-length capsule
		pending_shapes.push_back(mk(sot_pkg::OP_SEGMENT, 0, 0, 0, 0, 3 << 16, 3 << 16,
			3 << 16, 3 << 16, 1 << 16, 0));
		pending_shapes.push_back(mk(sot_pkg::OP_SEGMENT, 1 << 16, 0, 46341, 46341, 0, 0,
			10 << 16, 0, 2 << 16, 0));
		pending_shapes.push_back(mk(sot_pkg::OP_SEGMENT, 0, 0, 0, 0,
			32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 0));
		pending_shapes.push_back(mk(sot_pkg::OP_SEGMENT, 0, 0, 65536, 0, 32'h8000_0000, 0,
			32'h7FFF_FFFF, 0, 1 << 16, 0));
		pending_shapes.push_back(mk(sot_pkg::OP_POLYGON, 0, 0, 0, 0, 1 << 16, 0, 0, 0, 0, 0));
		pending_shapes.push_back(mk(sot_pkg::OP_POLYGON, 1, 2, 65536, 0, 0, 1 << 16,
			0, 0, 0, 0));
		pending_shapes.push_back(mk(sot_pkg::OP_POLYGON, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 1));
		pending_shapes.push_back(mk(sot_pkg::OP_NONE, -1, -1, -1, -1, -1, -1, -1, -1,
			31'h7FFF_FFFF, 1));
		pending_shapes.push_back(mk(sot_pkg::OP_POLYGON, 5, 5, 6554, 6554, 9, 9, 0, 0, 0, 1));
		// random: polygons as runs that mostly end on a last vertex, other shapes between
		n = 0;
		while (n < 200) begin
			case ($urandom_range(0, 9)) inside
				0, 1, 2: pending_shapes.push_back(rnd_shape(sot_pkg::OP_CIRCLE));
				3, 4, 5: pending_shapes.push_back(rnd_shape(sot_pkg::OP_SEGMENT));
				6: pending_shapes.push_back(rnd_shape(sot_pkg::OP_NONE));
				default: begin
					s = rnd_shape(sot_pkg::OP_POLYGON);
					for (int k = $urandom_range(1, 6); k > 0; k--) begin
						s.ax = rnd_val();
						s.ay = rnd_val();
						s.plast = (k == 1) ^ ($urandom_range(0, 15) == 0);
						pending_shapes.push_back(s);
						n++;
					end
				end
			endcase
			n++;
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_shapes.size() == 0 && !in_valid);
		wait (expected_verts.size() == 0);
		// opcode 3 leaves nothing to wait for, so give the pipeline time to drain
		repeat (DRAIN_CYC) @(posedge clk);
		if (mismatches == 0 && expected_verts.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// ---------------------------------------------------------------- driver

	always @(posedge clk or negedge arst_n) begin
		shape_t s;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_gap = 0;
		end else begin
			// record the transaction the block takes at this edge
			if (in_valid && !in_stall)
				tessellate(mk(opcode, pos_x, pos_y, rot_x, rot_y, point_a_x, point_a_y,
					point_b_x, point_b_y, radius, poly_last));
			// hold the payload while stalled, else advance
			if (!(in_valid && in_stall)) begin
				if (in_gap > 0) begin
					in_valid <= 1'b0;
					in_gap--;
				end else if (pending_shapes.size() > 0) begin
					s = pending_shapes.pop_front();
					opcode <= s.op; pos_x <= s.px; pos_y <= s.py;
					rot_x <= s.rx; rot_y <= s.ry;
					point_a_x <= s.ax; point_a_y <= s.ay;
					point_b_x <= s.bx; point_b_y <= s.by;
					radius <= s.rad; poly_last <= s.plast;
					in_valid <= 1'b1;
					if ($urandom_range(0, 15) == 0) burst = !burst;
					in_gap = burst ? 0 : $urandom_range(0, 3);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- monitor

	always @(posedge clk or negedge arst_n) begin
		vertex_t e;
		if (!arst_n) begin
			vert_stall <= 1'b0;
			stall_left = 0;
			idle_cycles = 0;
		end else begin
			if (vert_valid && !vert_stall) begin
				if (expected_verts.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected vertex x=%0d y=%0d last=%0b",
							vert_x, vert_y, last_vertex);
				end else begin
					e = expected_verts.pop_front();
					if (vert_x !== e.x || vert_y !== e.y || last_vertex !== e.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"vertex mismatch: exp x=%0d y=%0d last=%0b, ",
								"got x=%0d y=%0d last=%0b"},
								e.x, e.y, e.last, vert_x, vert_y, last_vertex);
					end
				end
				stall_left = burst ? 0 : $urandom_range(0, 3);
			end
			if (stall_left > 0) begin
				vert_stall <= 1'b1;
				stall_left--;
			end else begin
				vert_stall <= 1'b0;
			end

			// watchdog: count cycles with no transaction on either channel
			if ((in_valid && !in_stall) || (vert_valid && !vert_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

endmodule
